[rtl/page_buffer_bitmap_blit_defines.svh]
// Assertion macros for the page buffer bitmap blit checker.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef PAGE_BUFFER_BITMAP_BLIT_DEFINES_SVH
`define PAGE_BUFFER_BITMAP_BLIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PBB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define PBB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pbb_pkg.sv]
// Package for the page buffer bitmap blit: frame store geometry, field layout,
// command and register codes, controller states. No dependencies.
package pbb_pkg;

  localparam int FB_WIDTH  = 128;
  localparam int FB_HEIGHT = 64;
  localparam int FB_PAGES  = (FB_HEIGHT + 7) / 8;
  localparam int FB_BYTES  = FB_WIDTH * FB_PAGES;
  localparam int FB_AW     = $clog2(FB_BYTES);

  localparam int ROW_W  = 10;
  localparam int COL_W  = 7;
  localparam int BYTE_W = 8;
  localparam int FBA_W  = 10;

  localparam int ROW_LSB  = 0;
  localparam int COL_LSB  = ROW_LSB + ROW_W;
  localparam int BYTE_LSB = COL_LSB + COL_W;
  localparam int FBA_LSB  = BYTE_LSB + BYTE_W;
  localparam int IN_TDATA_W  = ((FBA_LSB + FBA_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // signed screen and window coordinates
  localparam int POS_W = 13;

  localparam logic CMD_DRAW = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_X       = 3'd0,
    CFG_SRC_Y       = 3'd1,
    CFG_BLIT_WIDTH  = 3'd2,
    CFG_BLIT_HEIGHT = 3'd3,
    CFG_DEST_X      = 3'd4,
    CFG_DEST_Y      = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_DRAW,
    ST_RD_MEM,
    ST_RD_OUT
  } state_t;

endpackage

[rtl/page_buffer_bitmap_blit.sv]
// Top level of the page buffer bitmap blit: frame store memory, pixel-serial
// draw sequencer, read path and configuration registers. Uses pbb_pkg.
//
// Monochrome frame store of FB_WIDTH x FB_HEIGHT pixels in vertical pages of
// eight rows. A draw transfer (tuser = 0) writes the pixels of one source byte
// that fall inside the configured window and on the screen: a setup state, then
// one pixel per cycle shifted out of the source byte, each pixel doing a
// read-modify-write through the single read port of the frame store
// (the write follows in the cycle after its read). A read transfer (tuser = 1)
// reads the store, then loads the output register once the output is free.
// Draw transfers are taken while a read result waits at the output. After
// reset the store is cleared one byte a cycle, all FB_BYTES (1024) bytes, with
// in_tready low; configuration writes are always taken.
module page_buffer_bitmap_blit
  import pbb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [9:0] src_row, [16:10] src_byte_col, [24:17] src_byte, [34:25] fb_addr
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] command
  input  logic [0:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [7:0] read_data
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // configuration
  logic [9:0]         src_x_r, src_y_r;
  logic [10:0]        blit_w_r, blit_h_r;
  logic signed [10:0] dest_x_r, dest_y_r;

  // control
  state_t             state_r, state_nxt;
  logic [FB_AW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [2:0]         pix_cnt_r, pix_cnt_nxt;
  logic               wp_vld_r, wp_vld_nxt;
  logic               out_vld_r, out_vld_nxt;

  // payload
  logic [ROW_W-1:0]       row_r, row_nxt;
  logic [COL_W-1:0]       col_r, col_nxt;
  logic [BYTE_W-1:0]      bits_r, bits_nxt;
  logic [FBA_W-1:0]       fba_r, fba_nxt;
  logic                   oob_r, oob_nxt;
  logic                   line_ok_r, line_ok_nxt;
  logic [2:0]             ty_bit_r, ty_bit_nxt;
  logic [FB_AW-1:0]       base_r, base_nxt;
  logic signed [POS_W-1:0] diff_r, diff_nxt;
  logic signed [POS_W-1:0] tx_r, tx_nxt;
  logic [FB_AW-1:0]       wp_addr_r, wp_addr_nxt;
  logic                   wp_val_r, wp_val_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // frame store
  logic [BYTE_W-1:0] fb_mem [FB_BYTES];
  logic [BYTE_W-1:0] rdata_r;
  logic              rd_en;
  logic [FB_AW-1:0]  rd_addr;
  logic              mem_we;
  logic [FB_AW-1:0]  mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic [BYTE_W-1:0] bit_mask;

  // setup arithmetic
  logic signed [POS_W-1:0] row_d, ty, x0_d;
  logic                    row_ok, ty_ok, pix_ok;
  logic                    in_xfer;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign in_xfer    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_x_r  <= '0;
      src_y_r  <= '0;
      blit_w_r <= '0;
      blit_h_r <= '0;
      dest_x_r <= '0;
      dest_y_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SRC_X:       src_x_r  <= cfg_data[9:0];
        CFG_SRC_Y:       src_y_r  <= cfg_data[9:0];
        CFG_BLIT_WIDTH:  blit_w_r <= cfg_data;
        CFG_BLIT_HEIGHT: blit_h_r <= cfg_data;
        CFG_DEST_X:      dest_x_r <= $signed(cfg_data);
        CFG_DEST_Y:      dest_y_r <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_comb begin
    row_d  = $signed(POS_W'(row_r)) - $signed(POS_W'(src_y_r));
    row_ok = (row_d >= 0) && (row_d < $signed(POS_W'(blit_h_r)));
    ty     = POS_W'(dest_y_r) + row_d;
    ty_ok  = (ty >= 0) && (ty < $signed(POS_W'(FB_HEIGHT)));
    x0_d   = $signed(POS_W'({col_r, 3'b000})) - $signed(POS_W'(src_x_r));
    pix_ok = line_ok_r && (diff_r >= 0) && (diff_r < $signed(POS_W'(blit_w_r)))
             && (tx_r >= 0) && (tx_r < $signed(POS_W'(FB_WIDTH)));
  end

  always_comb begin
    state_nxt    = state_r;
    clr_cnt_nxt  = clr_cnt_r;
    pix_cnt_nxt  = pix_cnt_r;
    wp_vld_nxt   = 1'b0;
    out_vld_nxt  = out_vld_r && !out_tready;
    row_nxt      = row_r;
    col_nxt      = col_r;
    bits_nxt     = bits_r;
    fba_nxt      = fba_r;
    oob_nxt      = oob_r;
    line_ok_nxt  = line_ok_r;
    ty_bit_nxt   = ty_bit_r;
    base_nxt     = base_r;
    diff_nxt     = diff_r;
    tx_nxt       = tx_r;
    wp_addr_nxt  = wp_addr_r;
    wp_val_nxt   = wp_val_r;
    out_data_nxt = out_data_r;
    rd_en        = 1'b0;
    rd_addr      = base_r + FB_AW'(tx_r);

    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == FB_AW'(FB_BYTES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          row_nxt  = in_tdata[ROW_LSB +: ROW_W];
          col_nxt  = in_tdata[COL_LSB +: COL_W];
          bits_nxt = in_tdata[BYTE_LSB +: BYTE_W];
          fba_nxt  = in_tdata[FBA_LSB +: FBA_W];
          oob_nxt  = 32'(in_tdata[FBA_LSB +: FBA_W]) >= FB_BYTES;
          state_nxt = (in_tuser[0] == CMD_READ) ? ST_RD_MEM : ST_SETUP;
        end
      end
      ST_SETUP: begin
        line_ok_nxt = row_ok && ty_ok;
        ty_bit_nxt  = ty[2:0];
        base_nxt    = FB_AW'(32'(ty[POS_W-1:3]) * FB_WIDTH);
        diff_nxt    = x0_d;
        tx_nxt      = POS_W'(dest_x_r) + x0_d;
        pix_cnt_nxt = '0;
        state_nxt   = ST_DRAW;
      end
      ST_DRAW: begin
        rd_en       = pix_ok;
        wp_vld_nxt  = pix_ok;
        wp_addr_nxt = rd_addr;
        wp_val_nxt  = bits_r[BYTE_W-1];
        bits_nxt    = {bits_r[BYTE_W-2:0], 1'b0};
        diff_nxt    = diff_r + 1'b1;
        tx_nxt      = tx_r + 1'b1;
        pix_cnt_nxt = pix_cnt_r + 1'b1;
        if (pix_cnt_r == 3'd7) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RD_MEM: begin
        rd_en     = 1'b1;
        rd_addr   = FB_AW'(fba_r);
        state_nxt = ST_RD_OUT;
      end
      ST_RD_OUT: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = oob_r ? '0 : rdata_r;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    bit_mask = BYTE_W'(1) << ty_bit_r;
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else begin
      mem_we    = wp_vld_r;
      mem_waddr = wp_addr_r;
      mem_wdata = wp_val_r ? (rdata_r | bit_mask) : (rdata_r & ~bit_mask);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      fb_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_r <= fb_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      pix_cnt_r <= '0;
      wp_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      pix_cnt_r <= pix_cnt_nxt;
      wp_vld_r  <= wp_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    bits_r     <= bits_nxt;
    fba_r      <= fba_nxt;
    oob_r      <= oob_nxt;
    line_ok_r  <= line_ok_nxt;
    ty_bit_r   <= ty_bit_nxt;
    base_r     <= base_nxt;
    diff_r     <= diff_nxt;
    tx_r       <= tx_nxt;
    wp_addr_r  <= wp_addr_nxt;
    wp_val_r   <= wp_val_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

[rtl/pbb_checker.sv]
// Port-level checker for page_buffer_bitmap_blit, bound to the top level.
// Uses pbb_pkg and the macros in page_buffer_bitmap_blit_defines.svh.
`include "page_buffer_bitmap_blit_defines.svh"

module pbb_checker
  import pbb_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [0:0]             in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  `PBB_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed or dropped")
  `PBB_ASSERT_NEXT(a_in_busy, in_tvalid && in_tready, !in_tready, "input taken again before previous transfer finished")
  `PBB_ASSERT_NEXT(a_draw_silent, in_tvalid && in_tready && (in_tuser[0] == CMD_DRAW) && !out_tvalid, !out_tvalid, "draw transfer produced a result")
  `PBB_ASSERT_NEXT(a_read_latency, in_tvalid && in_tready && (in_tuser[0] == CMD_READ) && !out_tvalid, !out_tvalid, "read result appeared without memory latency")

endmodule

bind page_buffer_bitmap_blit pbb_checker u_pbb_checker (.*);

[test/testbench.sv]
// Self-checking testbench for page_buffer_bitmap_blit: draw and read transfers with random
// idling on both sides, every read result checked against a frame store predictor or a
// directed expected value. Depends on pbb_pkg and the page_buffer_bitmap_blit RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pbb_pkg::*;

  localparam int RANDOM_ITEMS  = 1550;
  localparam int SETTLE_CYCLES = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

  typedef enum logic [1:0] {STEP_CONFIG, STEP_DRAW, STEP_READ} step_kind_t;

  typedef struct {
    step_kind_t            kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic [ROW_W-1:0]      row;
    logic [COL_W-1:0]      col;
    logic [BYTE_W-1:0]     pixels;
    logic [FBA_W-1:0]      addr;
    bit                    typed;
    logic [7:0]            typed_value;
  } step_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [0:0]             in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // predicted frame store and window settings
  logic [7:0] model_store [FB_BYTES];
  int         win_src_x = 0;
  int         win_src_y = 0;
  int         win_width = 0;
  int         win_height = 0;
  int         win_dest_x = 0;
  int         win_dest_y = 0;

  logic [7:0] expected_bytes [$];
  step_t      directed_steps [$];
  int         error_count = 0;
  int         in_count = 0;
  int         out_count = 0;
  bit         in_burst = 1'b0;
  bit         out_burst = 1'b0;

  always #4 clk = ~clk;

  page_buffer_bitmap_blit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  task automatic report(input string what);
    error_count++;
    $display("%0t ns mismatch: %s", $time, what);
  endtask

  function automatic void model_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_SRC_X:       win_src_x = int'(val[9:0]);
      CFG_SRC_Y:       win_src_y = int'(val[9:0]);
      CFG_BLIT_WIDTH:  win_width = int'(val);
      CFG_BLIT_HEIGHT: win_height = int'(val);
      CFG_DEST_X:      win_dest_x = int'($signed(val));
      CFG_DEST_Y:      win_dest_y = int'($signed(val));
      default: ;
    endcase
  endfunction

  function automatic void model_draw(logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                                     logic [BYTE_W-1:0] pixels);
    int r, x, tx, ty, b, a;
    r = int'(row);
    if (r < win_src_y || r >= win_src_y + win_height) return;
    ty = win_dest_y + r - win_src_y;
    for (b = 0; b < 8; b++) begin
      x = int'(col) * 8 + b;
      tx = win_dest_x + x - win_src_x;
      if (x >= win_src_x && x < win_src_x + win_width &&
          tx >= 0 && tx < FB_WIDTH && ty >= 0 && ty < FB_HEIGHT) begin
        a = (ty / 8) * FB_WIDTH + tx;
        model_store[a][ty % 8] = pixels[7 - b];
      end
    end
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, int val);
    step_t s;
    s = '{STEP_CONFIG, idx, CFG_DATA_W'(val), '0, '0, '0, '0, 1'b0, '0};
    directed_steps.push_back(s);
  endfunction

  function automatic void add_draw(int row, int col, int pixels);
    step_t s;
    s = '{STEP_DRAW, '0, '0, ROW_W'(row), COL_W'(col), BYTE_W'(pixels), FBA_W'($urandom),
          1'b0, '0};
    directed_steps.push_back(s);
  endfunction

  function automatic void add_read(int addr, bit typed, logic [7:0] val);
    step_t s;
    s = '{STEP_READ, '0, '0, ROW_W'($urandom), COL_W'($urandom), BYTE_W'($urandom),
          FBA_W'(addr), typed, val};
    directed_steps.push_back(s);
  endfunction

  function automatic int pick(int lo, int hi, int typ_lo, int typ_hi);
    if ($urandom_range(0, 5) == 0) return $urandom_range(0, 1) ? hi : lo;
    return typ_lo + int'($urandom_range(0, typ_hi - typ_lo));
  endfunction

  function automatic step_t random_step();
    step_t s;
    int    r, c, sel;
    s = '{STEP_DRAW, '0, '0, ROW_W'($urandom), COL_W'($urandom), BYTE_W'($urandom),
          FBA_W'($urandom), 1'b0, '0};
    sel = $urandom_range(0, 19);
    if (sel < 8) begin
      s.kind = STEP_READ;
    end else if (sel < 17) begin
      // aim at the window, with a margin of rows and bytes either side
      r = win_src_y - 2 + int'($urandom_range(0, win_height + 3));
      c = (win_src_x - 8 + int'($urandom_range(0, win_width + 15))) / 8;
      r = (r < 0) ? 0 : (r > 1023) ? 1023 : r;
      c = (c < 0) ? 0 : (c > 127) ? 127 : c;
      s.row = ROW_W'(r);
      s.col = COL_W'(c);
    end
    return s;
  endfunction

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_ready);
    model_config(idx, CFG_DATA_W'(val));
  endtask

  task automatic send_item(step_t s);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= (s.kind == STEP_READ) ? CMD_READ : CMD_DRAW;
    in_tdata  <= IN_TDATA_W'({s.addr, s.pixels, s.col, s.row});
    do @(posedge clk); while (!in_tready);
    if (s.kind == STEP_READ)
      expected_bytes.push_back(s.typed ? s.typed_value : model_store[s.addr]);
    else
      model_draw(s.row, s.col, s.pixels);
    in_count++;
    if (in_count % 50 == 0) in_burst = ($urandom_range(0, 2) == 0);
  endtask

  // draws leave no result, so allow the last one to finish as well
  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(int phase);
    int sx, sy, w, h, dx, dy;
    case (phase)
      0: begin sx = 0;    sy = 0;    w = 1024; h = 1024; dx = 0;     dy = 0;     end
      1: begin sx = 1023; sy = 1023; w = 1;    h = 1;    dx = 127;   dy = 63;    end
      2: begin sx = 0;    sy = 0;    w = 1024; h = 1024; dx = -1024; dy = -1024; end
      3: begin sx = 1023; sy = 1023; w = 1024; h = 1024; dx = 1023;  dy = 1023;  end
      default: begin
        sx = pick(0, 1023, 0, 1023);
        sy = pick(0, 1023, 0, 1023);
        w  = pick(0, 1024, 1, 200);
        h  = pick(0, 1024, 1, 80);
        dx = pick(-1024, 1023, -24, 140);
        dy = pick(-1024, 1023, -24, 80);
      end
    endcase
    write_register(CFG_SRC_X, sx);
    write_register(CFG_SRC_Y, sy);
    write_register(CFG_BLIT_WIDTH, w);
    write_register(CFG_BLIT_HEIGHT, h);
    write_register(CFG_DEST_X, dx);
    write_register(CFG_DEST_Y, dy);
    if ($urandom_range(0, 3) == 0)
      write_register($urandom_range(0, 1) ? CFG_SPARE_6 : CFG_SPARE_7, $urandom);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int i, total, phase, n;
    for (i = 0; i < FB_BYTES; i++) model_store[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // cleared store, empty window after reset
    add_read(0, 1'b1, 8'h00);
    add_read(FB_BYTES - 1, 1'b1, 8'h00);
    add_draw(0, 0, 8'hFF);
    add_read(0, 1'b1, 8'h00);
    add_cfg(CFG_BLIT_WIDTH, 1024);
    add_cfg(CFG_BLIT_HEIGHT, 1024);
    add_cfg(CFG_SPARE_6, 11'h7FF);
    add_cfg(CFG_SPARE_7, 11'h5AA);
    add_draw(0, 0, 8'hFF);
    add_read(0, 1'b1, 8'h01);
    add_draw(63, 15, 8'hA5);
    add_read(FB_BYTES - 1, 1'b1, 8'h80);
    add_read(FB_BYTES - 8, 1'b1, 8'h80);
    add_draw(64, 0, 8'hFF);  // below the screen
    add_draw(0, 16, 8'hFF);  // right of the screen
    add_read(0, 1'b1, 8'h01);
    add_draw(0, 0, 8'h00);
    add_read(0, 1'b1, 8'h00);
    add_cfg(CFG_BLIT_HEIGHT, 0);
    add_draw(0, 0, 8'hFF);
    add_read(0, 1'b1, 8'h00);
    // window partly off the top left corner
    add_cfg(CFG_BLIT_HEIGHT, 16);
    add_cfg(CFG_BLIT_WIDTH, 16);
    add_cfg(CFG_DEST_X, -3);
    add_cfg(CFG_DEST_Y, -2);
    add_draw(2, 0, 8'hFF);
    add_read(4, 1'b0, 8'h00);
    add_read(5, 1'b0, 8'h00);
    add_cfg(CFG_SRC_X, 1023);
    add_cfg(CFG_SRC_Y, 1023);
    add_cfg(CFG_BLIT_WIDTH, 1);
    add_cfg(CFG_BLIT_HEIGHT, 1);
    add_cfg(CFG_DEST_X, 127);
    add_cfg(CFG_DEST_Y, 63);
    add_draw(1023, 127, 8'h01);
    add_draw(1023, 127, 8'hFE);
    add_read(FB_BYTES - 1, 1'b0, 8'h00);
    add_cfg(CFG_DEST_X, -1024);
    add_cfg(CFG_DEST_Y, -1024);
    add_draw(1023, 127, 8'hFF);
    add_read(FB_BYTES - 1, 1'b0, 8'h00);

    for (i = 0; i < directed_steps.size(); i++) begin
      if (directed_steps[i].kind == STEP_CONFIG) begin
        if (i > 0 && directed_steps[i-1].kind != STEP_CONFIG) settle();
        write_register(directed_steps[i].reg_idx, int'(directed_steps[i].reg_val));
      end else begin
        cfg_valid <= 1'b0;
        send_item(directed_steps[i]);
      end
    end

    total = 0;
    phase = 0;
    while (total < RANDOM_ITEMS) begin
      settle();
      write_window(phase);
      n = $urandom_range(60, 160);
      if (n > RANDOM_ITEMS - total) n = RANDOM_ITEMS - total;
      repeat (n) send_item(random_step());
      total += n;
      phase++;
    end

    settle();
    if (error_count == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

  initial begin : result_side
    int         stall;
    logic [7:0] want;
    wait (rst_n === 1'b1);
    forever begin
      stall = out_burst ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if (expected_bytes.size() == 0) begin
        report($sformatf("read_data %02h with no read outstanding", out_tdata));
      end else begin
        want = expected_bytes.pop_front();
        if (out_tdata !== want)
          report($sformatf("read_data %02h, expected %02h", out_tdata, want));
      end
      out_count++;
      if (out_count % 50 == 0) out_burst = ($urandom_range(0, 2) == 0);
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule
